// ----- rtl/stp_pkg.sv -----
package stp_pkg;

  // Default sizes, also the fixed field widths of the words
  localparam int SLOTS_DEF       = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MAX_RESULTS     = 64;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  // Request function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_CREATE = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;

  // Event codes
  localparam logic [2:0] EV_TIMEOUT  = 3'd0;
  localparam logic [2:0] EV_RELOADED = 3'd1;
  localparam logic [2:0] EV_EXPIRED  = 3'd2;
  localparam logic [2:0] EV_RUNNING  = 3'd3;
  localparam logic [2:0] EV_CREATED  = 3'd4;
  localparam logic [2:0] EV_FULL     = 3'd5;

  // Slot status codes
  localparam logic [2:0] TS_INVALID = 3'd0;
  localparam logic [2:0] TS_NORMAL  = 3'd1;
  localparam logic [2:0] TS_PAUSE   = 3'd2;
  localparam logic [2:0] TS_RESUME  = 3'd3;
  localparam logic [2:0] TS_KILLED  = 3'd4;

  localparam logic MODE_ONESHOT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  slot;
    logic        timer_mode;
    logic [31:0] reload_ticks;
    logic [2:0]  new_status;
  } stp_in_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [4:0] slot_index;
    logic       last;
  } stp_out_t;

  // One event from the sequencer to the output queue
  typedef struct packed {
    logic [2:0] code;
    logic [4:0] idx;
  } stp_ev_t;

  // Queue status seen by the sequencer
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } stp_evq_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_TICK_RD,
    S_TICK_EV,
    S_TICK_EV2,
    S_FLUSH
  } stp_state_t;

endpackage

// ----- rtl/stp_evq.sv -----
module stp_evq
  import stp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stp_ev_t       push_ev,
  input  logic          flush,
  output stp_evq_stat_t stat,
  output logic          out_valid,
  input  logic          out_ready,
  output stp_out_t      out_data
);

  logic                 pend_vld_r, pend_vld_nxt;
  stp_ev_t              pend_r, pend_nxt;
  logic                 out_vld_r, out_vld_nxt;
  stp_out_t             out_r, out_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_free;
  logic                 push_go;
  logic                 flush_go;

  assign out_free      = !out_vld_r || out_ready;
  assign stat.push_ok  = !pend_vld_r || out_free;
  assign stat.flush_ok = !pend_vld_r || out_free;
  assign push_go  = push && stat.push_ok && (cnt_r < RES_CNT_W'(MAX_RESULTS));
  assign flush_go = flush && stat.flush_ok;

  // Hold one event back so the final word of an item can carry last
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    cnt_nxt      = cnt_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (push_go) begin
      if (pend_vld_r) begin
        out_nxt     = '{event_code: pend_r.code, slot_index: pend_r.idx, last: 1'b0};
        out_vld_nxt = 1'b1;
      end
      pend_nxt     = push_ev;
      pend_vld_nxt = 1'b1;
      cnt_nxt      = cnt_r + 1'b1;
    end
    if (flush_go) begin
      if (pend_vld_r) begin
        out_nxt     = '{event_code: pend_r.code, slot_index: pend_r.idx, last: 1'b1};
        out_vld_nxt = 1'b1;
      end
      pend_vld_nxt = 1'b0;
      cnt_nxt      = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    flush_go |=> !pend_vld_r && cnt_r == '0)
    else $error("pending event survived a flush");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count above limit");
  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> cnt_r != '0)
    else $error("pending event without count");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(out_r))
    else $error("output word overwritten while stalled");
`endif

endmodule

// ----- rtl/software_timer_pool_top.sv -----
// Channel | Dir | Handshake                | Word
// in      | in  | in_valid / in_ready      | stp_in_t  (func, slot, mode, reload, status)
// out     | out | out_valid / out_ready    | stp_out_t (event_code, slot_index, last)
//
// Tick: accept, then a scan of every slot in order by the single slot evaluator and
// its registered slot memory read, with up to two events per slot, then a flush.
// Create: a scan for the lowest free slot, then a flush. Set status: written on accept.
// in_ready is high only between items.
// Reset clears the used bits and control; slot memories are not cleared.
// A stalled out channel holds the scan until the event queue has room.
module software_timer_pool_top
  import stp_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  stp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output stp_out_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  stp_state_t           state_r, state_nxt;
  stp_in_t              req_r, req_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [2:0]           ev2_r, ev2_nxt;
  logic [SLOTS-1:0]     used_r;

  // Slot memories
  logic [2:0]             status_mem [SLOTS];
  logic                   mode_mem   [SLOTS];
  logic [COUNT_WIDTH-1:0] period_mem [SLOTS];
  logic [COUNT_WIDTH-1:0] count_mem  [SLOTS];
  logic [2:0]             st_q;
  logic                   mode_q;
  logic [COUNT_WIDTH-1:0] per_q;
  logic [COUNT_WIDTH-1:0] cnt_q;

  logic                   we_status, we_mode, we_period, we_count;
  logic [IW-1:0]          wa;
  logic [2:0]             wd_status;
  logic [COUNT_WIDTH-1:0] wd_count;
  logic                   used_set, used_clr;

  logic                   push, flush;
  stp_ev_t                push_ev;
  stp_evq_stat_t          qstat;

  logic [8:0]             slot_ext;
  logic [IW-1:0]          slot_idx;
  logic                   slot_ok;
  logic [8:0]             idx_ext;
  logic [4:0]             idx5;
  logic                   idx_last;
  logic [63:0]            reload_ext;
  logic [COUNT_WIDTH-1:0] reload_cw;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   cnt_zero;
  logic                   accept;

  assign accept     = in_valid && in_ready;
  assign slot_ext   = 9'(in_data.slot);
  assign slot_idx   = slot_ext[IW-1:0];
  assign slot_ok    = slot_ext < 9'(SLOTS);
  assign idx_ext    = 9'(idx_r);
  assign idx5       = idx_ext[4:0];
  assign idx_last   = idx_r == IDX_LAST;
  assign reload_ext = 64'(req_r.reload_ticks);
  assign reload_cw  = reload_ext[COUNT_WIDTH-1:0];

  // Shared evaluator: saturating decrement and zero test
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
  assign cnt_zero = cnt_dec == '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_TICK) begin
            state_nxt = S_TICK_RD;
          end else if (in_data.func == FUNC_CREATE) begin
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        if ((!used_r[idx_r] || idx_last) && qstat.push_ok) begin
          state_nxt = S_FLUSH;
        end
      end
      S_TICK_RD: begin
        if (used_r[idx_r]) begin
          state_nxt = S_TICK_EV;
        end else if (idx_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_TICK_EV: begin
        case (st_q)
          TS_INVALID, TS_KILLED, TS_RESUME, TS_PAUSE: begin
            state_nxt = idx_last ? S_FLUSH : S_TICK_RD;
          end
          default: begin
            if (qstat.push_ok) begin
              if (cnt_zero) begin
                state_nxt = S_TICK_EV2;
              end else begin
                state_nxt = idx_last ? S_FLUSH : S_TICK_RD;
              end
            end
          end
        endcase
      end
      S_TICK_EV2: begin
        if (qstat.push_ok) begin
          state_nxt = idx_last ? S_FLUSH : S_TICK_RD;
        end
      end
      S_FLUSH: begin
        if (qstat.flush_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs, memory writes and datapath updates
  always_comb begin
    in_ready  = 1'b0;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    ev2_nxt   = ev2_r;
    we_status = 1'b0;
    we_mode   = 1'b0;
    we_period = 1'b0;
    we_count  = 1'b0;
    wa        = idx_r;
    wd_status = req_r.new_status;
    wd_count  = reload_cw;
    used_set  = 1'b0;
    used_clr  = 1'b0;
    push      = 1'b0;
    push_ev   = '{code: EV_CREATED, idx: idx5};
    flush     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          req_nxt = in_data;
          idx_nxt = '0;
          // Set status lands at once on an occupied slot
          if (in_data.func == FUNC_SET && slot_ok && used_r[slot_idx]) begin
            we_status = 1'b1;
            wa        = slot_idx;
            wd_status = in_data.new_status;
          end
        end
      end
      S_FIND: begin
        if (!used_r[idx_r]) begin
          push = 1'b1;
          if (qstat.push_ok) begin
            we_status = 1'b1;
            we_mode   = 1'b1;
            we_period = 1'b1;
            we_count  = 1'b1;
            used_set  = 1'b1;
          end
        end else if (idx_last) begin
          push    = 1'b1;
          push_ev = '{code: EV_FULL, idx: 5'd0};
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK_RD: begin
        if (!used_r[idx_r] && !idx_last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK_EV: begin
        wd_count = per_q;
        case (st_q)
          TS_INVALID: begin
            idx_nxt = idx_r + 1'b1;
          end
          TS_KILLED: begin
            used_clr = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
          TS_RESUME: begin
            we_count  = 1'b1;
            we_status = 1'b1;
            wd_status = TS_NORMAL;
            idx_nxt   = idx_r + 1'b1;
          end
          TS_PAUSE: begin
            we_count = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
          default: begin
            push = 1'b1;
            if (cnt_zero) begin
              push_ev = '{code: EV_TIMEOUT, idx: idx5};
              if (qstat.push_ok) begin
                if (mode_q == MODE_ONESHOT) begin
                  used_clr = 1'b1;
                  ev2_nxt  = EV_EXPIRED;
                end else begin
                  we_count = 1'b1;
                  ev2_nxt  = EV_RELOADED;
                end
              end
            end else begin
              push_ev = '{code: EV_RUNNING, idx: idx5};
              if (qstat.push_ok) begin
                we_count = 1'b1;
                wd_count = cnt_dec;
                idx_nxt  = idx_r + 1'b1;
              end
            end
          end
        endcase
      end
      S_TICK_EV2: begin
        push    = 1'b1;
        push_ev = '{code: ev2_r, idx: idx5};
        if (qstat.push_ok) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state and used bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (used_set) begin
        used_r[wa] <= 1'b1;
      end
      if (used_clr) begin
        used_r[wa] <= 1'b0;
      end
    end
  end

  // Request, scan index and second event
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    ev2_r <= ev2_nxt;
  end

  // Write slot memories
  always_ff @(posedge clk) begin
    if (we_status) begin
      status_mem[wa] <= wd_status;
    end
    if (we_mode) begin
      mode_mem[wa] <= req_r.timer_mode;
    end
    if (we_period) begin
      period_mem[wa] <= reload_cw;
    end
    if (we_count) begin
      count_mem[wa] <= wd_count;
    end
  end

  // Read slot memories at the scan index
  always_ff @(posedge clk) begin
    st_q   <= status_mem[idx_r];
    mode_q <= mode_mem[idx_r];
    per_q  <= period_mem[idx_r];
    cnt_q  <= count_mem[idx_r];
  end

  stp_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ev   (push_ev),
    .flush     (flush),
    .stat      (qstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !push && !flush)
    else $error("event traffic while taking a new word");
  a_ev2_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TICK_EV2 |-> ev2_r == EV_EXPIRED || ev2_r == EV_RELOADED)
    else $error("bad second event code");
  a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
    used_set |-> !used_r[wa])
    else $error("create claimed an occupied slot");
`endif

endmodule

// ----- bench/tb_software_timer_pool_top.sv -----
`timescale 1ns / 100ps

module tb_software_timer_pool_top;
  import stp_pkg::*;

  localparam logic       MODE_AUTO  = 1'b0;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [2:0] TS_SPARE   = 3'd7;
  localparam int         ITEM_GOAL  = 150;
  localparam int         DRAIN_CYC  = 200;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  stp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  stp_out_t out_data;

  // Requests waiting to be driven, events waiting to be seen
  stp_in_t  req_q [$];
  stp_out_t event_q [$];

  // Shadow copy of the timer slots
  bit          tm_used   [SLOTS_DEF];
  logic [2:0]  tm_status [SLOTS_DEF];
  logic        tm_mode   [SLOTS_DEF];
  logic [31:0] tm_period [SLOTS_DEF];
  logic [31:0] tm_count  [SLOTS_DEF];

  int n_queued  = 0;
  int n_ticks   = 0;
  int n_creates = 0;
  int n_sets    = 0;
  int n_full    = 0;
  int n_events  = 0;
  int n_errors  = 0;

  int unsigned in_wait  = 0;
  int unsigned out_wait = 0;
  bit          in_quiet  = 1'b0;
  bit          out_quiet = 1'b0;

  software_timer_pool_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic stp_out_t mk_event(logic [2:0] code, int idx);
    stp_out_t ev;
    ev.event_code = code;
    ev.slot_index = idx[4:0];
    ev.last       = 1'b0;
    return ev;
  endfunction

  // Apply one request to the shadow slots and queue the events it causes
  function automatic void predict_request(stp_in_t rq);
    stp_out_t evs [$];
    stp_out_t ev;
    bit       found;
    found = 1'b0;
    case (rq.func)
      FUNC_TICK: begin
        n_ticks++;
        for (int s = 0; s < SLOTS_DEF; s++) begin
          if (!tm_used[s] || tm_status[s] == TS_INVALID) continue;
          if (tm_status[s] == TS_KILLED) begin
            tm_used[s] = 1'b0;
            continue;
          end
          if (tm_status[s] == TS_RESUME) begin
            tm_count[s]  = tm_period[s];
            tm_status[s] = TS_NORMAL;
            continue;
          end
          if (tm_status[s] == TS_PAUSE) begin
            tm_count[s] = tm_period[s];
            continue;
          end
          // Normal and the spare codes count down
          if (tm_count[s] != 0) tm_count[s] = tm_count[s] - 1;
          if (tm_count[s] == 0) begin
            evs.push_back(mk_event(EV_TIMEOUT, s));
            if (tm_mode[s] == MODE_ONESHOT) begin
              evs.push_back(mk_event(EV_EXPIRED, s));
              tm_used[s] = 1'b0;
            end else begin
              tm_count[s] = tm_period[s];
              evs.push_back(mk_event(EV_RELOADED, s));
            end
          end else begin
            evs.push_back(mk_event(EV_RUNNING, s));
          end
        end
      end
      FUNC_CREATE: begin
        n_creates++;
        for (int s = 0; s < SLOTS_DEF; s++) begin
          if (!found && !tm_used[s]) begin
            found        = 1'b1;
            tm_used[s]   = 1'b1;
            tm_mode[s]   = rq.timer_mode;
            tm_period[s] = rq.reload_ticks;
            tm_count[s]  = rq.reload_ticks;
            tm_status[s] = rq.new_status;
            evs.push_back(mk_event(EV_CREATED, s));
          end
        end
        if (!found) begin
          n_full++;
          evs.push_back(mk_event(EV_FULL, 0));
        end
      end
      FUNC_SET: begin
        n_sets++;
        if (tm_used[rq.slot]) tm_status[rq.slot] = rq.new_status;
      end
      default: ;
    endcase
    // Flag the final event of this request
    if (evs.size() != 0) begin
      ev = evs[evs.size() - 1];
      ev.last = 1'b1;
      evs[evs.size() - 1] = ev;
    end
    foreach (evs[i]) event_q.push_back(evs[i]);
  endfunction

  function automatic void queue_req(logic [1:0] f, int s, logic m, logic [31:0] r,
                                    logic [2:0] st);
    stp_in_t rq;
    rq.func         = f;
    rq.slot         = s[4:0];
    rq.timer_mode   = m;
    rq.reload_ticks = r;
    rq.new_status   = st;
    req_q.push_back(rq);
    if (f != FUNC_SPARE) n_queued++;
  endfunction

  function automatic logic [31:0] pick_reload();
    return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4);
  endfunction

  function automatic logic [2:0] pick_status();
    return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 4)) : TS_NORMAL;
  endfunction

  function automatic int pick_slot();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
  endfunction

  // Driver: launch words from the request queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else begin
      if (in_valid && in_ready) predict_request(in_data);
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (req_q.size() != 0) begin
        if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
        in_data  <= req_q.pop_front();
        in_valid <= 1'b1;
        in_wait  <= in_quiet ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall the result channel at random and check each word
  always @(posedge clk) begin : result_check
    stp_out_t    want;
    int unsigned w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && out_ready) begin
      n_events++;
      if (event_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word, expected none, got code %0d slot %0d last %0d",
                 $time, out_data.event_code, out_data.slot_index, out_data.last);
      end else begin
        want = event_q.pop_front();
        if (out_data.event_code !== want.event_code) begin
          n_errors++;
          $display("%0t: event_code expected %0d got %0d", $time, want.event_code,
                   out_data.event_code);
        end
        if (out_data.slot_index !== want.slot_index) begin
          n_errors++;
          $display("%0t: slot_index expected %0d got %0d", $time, want.slot_index,
                   out_data.slot_index);
        end
        if (out_data.last !== want.last) begin
          n_errors++;
          $display("%0t: last expected %0d got %0d", $time, want.last, out_data.last);
        end
      end
      if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
      w = out_quiet ? 0 : $urandom_range(0, 9);
      out_wait  <= w;
      out_ready <= (w == 0);
    end else if (out_wait != 0) begin
      out_wait  <= out_wait - 1;
      out_ready <= (out_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Empty pool and ignored requests
    queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);
    queue_req(FUNC_SET, 5, MODE_AUTO, 32'd0, TS_KILLED);
    queue_req(FUNC_SPARE, 31, MODE_ONESHOT, 32'hFFFF_FFFF, TS_SPARE);
    // At least one timer per status, with the reload extremes
    queue_req(FUNC_CREATE, 0, MODE_AUTO, 32'd1, TS_NORMAL);
    queue_req(FUNC_CREATE, 0, MODE_ONESHOT, 32'd2, TS_NORMAL);
    queue_req(FUNC_CREATE, 0, MODE_AUTO, 32'd0, TS_NORMAL);
    queue_req(FUNC_CREATE, 0, MODE_ONESHOT, 32'hFFFF_FFFF, TS_PAUSE);
    queue_req(FUNC_CREATE, 0, MODE_AUTO, 32'h8000_0000, TS_RESUME);
    queue_req(FUNC_CREATE, 0, MODE_ONESHOT, 32'd3, TS_INVALID);
    queue_req(FUNC_CREATE, 0, MODE_AUTO, 32'd5, TS_KILLED);
    queue_req(FUNC_CREATE, 0, MODE_ONESHOT, 32'd1, TS_SPARE);
    queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);
    queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);
    queue_req(FUNC_SET, 3, MODE_AUTO, 32'd0, TS_RESUME);
    queue_req(FUNC_SET, 5, MODE_AUTO, 32'd0, TS_NORMAL);
    queue_req(FUNC_SET, 31, MODE_ONESHOT, 32'hFFFF_FFFF, TS_KILLED);
    queue_req(FUNC_CREATE, 0, MODE_ONESHOT, 32'd0, TS_NORMAL);
    queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);
    // Retire everything left
    queue_req(FUNC_SET, 0, MODE_AUTO, 32'd0, TS_KILLED);
    queue_req(FUNC_SET, 2, MODE_AUTO, 32'd0, TS_PAUSE);
    for (int s = 3; s < 6; s++) queue_req(FUNC_SET, s, MODE_AUTO, 32'd0, TS_KILLED);
    queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);
    queue_req(FUNC_SET, 2, MODE_AUTO, 32'd0, TS_KILLED);
    queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);

    // Fill the pool past full, then expire every slot in one tick
    for (int i = 0; i <= SLOTS_DEF; i++)
      queue_req(FUNC_CREATE, 0, MODE_ONESHOT, 32'd1, TS_NORMAL);
    queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);

    // Random mix: mostly create-then-tick runs, some status writes and noise
    while (n_queued < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(1, 3))
            queue_req(FUNC_CREATE, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                      pick_reload(), pick_status());
          repeat ($urandom_range(1, 4))
            queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);
        end
        6, 7: begin
          queue_req(FUNC_SET, pick_slot(), 1'($urandom_range(0, 1)), $urandom,
                    3'($urandom_range(0, 4)));
          queue_req(FUNC_TICK, 0, MODE_AUTO, 32'd0, TS_INVALID);
        end
        8: queue_req(FUNC_TICK, $urandom_range(0, 31), 1'($urandom_range(0, 1)), $urandom,
                     3'($urandom_range(0, 4)));
        default:
          queue_req(2'($urandom_range(0, 2)), $urandom_range(0, 31),
                    1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 4)));
      endcase
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all words sent and all events seen, then watch for strays
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || event_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("Covered %0d requests: %0d ticks, %0d creates (%0d on a full pool), %0d status writes.",
             n_ticks + n_creates + n_sets, n_ticks, n_creates, n_full, n_sets);
    $display("Checked %0d result words, %0d mismatches.", n_events, n_errors);
    if (n_errors == 0 && event_q.size() == 0) begin
      $display("tb_software_timer_pool_top: done, clean");
    end else begin
      $display("tb_software_timer_pool_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d events still expected.", event_q.size());
    $display("tb_software_timer_pool_top: done, errors");
    $finish;
  end

endmodule
